// ===== hdl/wrt_pkg.sv =====
package wrt_pkg;

    localparam int SLOTS   = 8;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SEQ_W   = 32;
    localparam int TIME_W  = 32;
    localparam int TICK_W  = 16;
    localparam int RET_W   = 3;
    localparam int KIND_W  = 2;
    localparam int REQ_W   = 2;
    localparam int CFG_W   = 1;
    localparam int PROD_W  = RET_W + 1 + TICK_W;

    localparam logic [REQ_W-1:0] REQ_SEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCAN = 2'd2;

    localparam logic [KIND_W-1:0] EV_RESEND   = 2'd0;
    localparam logic [KIND_W-1:0] EV_GIVEUP   = 2'd1;
    localparam logic [KIND_W-1:0] EV_COMPLETE = 2'd2;
    localparam logic [KIND_W-1:0] EV_OVERFLOW = 2'd3;

    localparam logic [CFG_W-1:0] CFG_TIMEOUT     = 1'd0;
    localparam logic [CFG_W-1:0] CFG_RETRY_LIMIT = 1'd1;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1;
    localparam logic [RET_W-1:0]  LIMIT_RESET   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_CMPL
    } t_state;

    typedef struct packed {
        logic send;
        logic ack;
        logic overflow;
        logic scan_init;
        logic scan_step;
        logic flush;
        logic complete;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic scan_end;
        logic complete;
        logic b_valid;
    } t_stat;

endpackage

// ===== hdl/window_retransmit_tracker.sv =====
// Retransmission tracker for one window of eight sent packets.
// A request is taken when i_start is high and o_busy is low; i_req_type
// selects send, acknowledge or scan, with i_seq_num and i_now_time.
// Send and acknowledge finish in the cycle they are taken, so o_busy stays
// low; a send to a full window raises one overflow word in the next cycle.
// A scan raises o_busy and reads one filled slot per cycle through a
// two-stage pipe (timeout product, then deadline add and compare); then
// a flush state sends the last held event, and a further state clears
// the window when all its slots are done.
// Each result word is held on the o_event ports for one cycle with
// o_event_valid high; the receiver cannot stall, and o_last_event marks the
// final word of a request. Each word of a scan waits for the next event of
// the scan or for the end of the walk.
// The configuration channel (i_cfg_valid, i_cfg_index, i_cfg_data) is
// always ready and must be written only while the block is idle.
// A synchronous reset empties the window and sets the timeout to one tick
// and the retry limit to five.
module window_retransmit_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [wrt_pkg::REQ_W-1:0]   i_req_type,
    input  logic [wrt_pkg::SEQ_W-1:0]   i_seq_num,
    input  logic [wrt_pkg::TIME_W-1:0]  i_now_time,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [wrt_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [wrt_pkg::TICK_W-1:0]  i_cfg_data,
    output logic                        o_event_valid,
    output logic [wrt_pkg::KIND_W-1:0]  o_event_kind,
    output logic [wrt_pkg::SEQ_W-1:0]   o_event_seq,
    output logic [wrt_pkg::RET_W-1:0]   o_attempt_num,
    output logic                        o_last_event
);

    wrt_pkg::t_cmd  w_cmd;
    wrt_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    wrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (o_busy)
    );

    wrt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_seq_num     (i_seq_num),
        .i_now_time    (i_now_time),
        .i_cfg_write   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_event_valid (o_event_valid),
        .o_event_kind  (o_event_kind),
        .o_event_seq   (o_event_seq),
        .o_attempt_num (o_attempt_num),
        .o_last_event  (o_last_event)
    );

    a_overflow_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req_type == wrt_pkg::REQ_SEND) && w_stat.full)
        |=> (o_event_valid && (o_event_kind == wrt_pkg::EV_OVERFLOW) && o_last_event))
        else $error("overflow word missing after send to full window");

    a_complete_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_valid && (o_event_kind == wrt_pkg::EV_COMPLETE))
        |-> (o_last_event && (o_event_seq == '0) && (o_attempt_num == '0)))
        else $error("window complete word malformed");

    a_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !w_stat.b_valid)
        else $error("scan pipe active while idle");

endmodule

// ===== hdl/wrt_ctrl.sv =====
module wrt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wrt_pkg::REQ_W-1:0]  i_req_type,
    input  wrt_pkg::t_stat             i_stat,
    output wrt_pkg::t_cmd              o_cmd,
    output logic                       o_busy
);

    wrt_pkg::t_state r_state;
    wrt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wrt_pkg::ST_IDLE: begin
                if (i_start && (i_req_type == wrt_pkg::REQ_SCAN)) begin
                    n_state = wrt_pkg::ST_SCAN;
                end
            end
            wrt_pkg::ST_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = wrt_pkg::ST_FLUSH;
                end
            end
            wrt_pkg::ST_FLUSH: begin
                n_state = i_stat.complete ? wrt_pkg::ST_CMPL : wrt_pkg::ST_IDLE;
            end
            wrt_pkg::ST_CMPL: begin
                n_state = wrt_pkg::ST_IDLE;
            end
            default: begin
                n_state = wrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            wrt_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (i_req_type)
                        wrt_pkg::REQ_SEND: begin
                            o_cmd.send     = !i_stat.full;
                            o_cmd.overflow = i_stat.full;
                        end
                        wrt_pkg::REQ_ACK: begin
                            o_cmd.ack = 1'b1;
                        end
                        wrt_pkg::REQ_SCAN: begin
                            o_cmd.scan_init = 1'b1;
                        end
                        default: begin
                            o_cmd = '0;
                        end
                    endcase
                end
            end
            wrt_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            wrt_pkg::ST_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            wrt_pkg::ST_CMPL: begin
                o_cmd.complete = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/wrt_datapath.sv =====
module wrt_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wrt_pkg::t_cmd               i_cmd,
    output wrt_pkg::t_stat              o_stat,
    input  logic [wrt_pkg::SEQ_W-1:0]   i_seq_num,
    input  logic [wrt_pkg::TIME_W-1:0]  i_now_time,
    input  logic                        i_cfg_write,
    input  logic [wrt_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [wrt_pkg::TICK_W-1:0]  i_cfg_data,
    output logic                        o_event_valid,
    output logic [wrt_pkg::KIND_W-1:0]  o_event_kind,
    output logic [wrt_pkg::SEQ_W-1:0]   o_event_seq,
    output logic [wrt_pkg::RET_W-1:0]   o_attempt_num,
    output logic                        o_last_event
);

    logic [wrt_pkg::SEQ_W-1:0]  r_seq     [wrt_pkg::SLOTS];
    logic [wrt_pkg::TIME_W-1:0] r_sent    [wrt_pkg::SLOTS];
    logic [wrt_pkg::RET_W-1:0]  r_retries [wrt_pkg::SLOTS];
    logic [wrt_pkg::SLOTS-1:0]  r_done;
    logic [wrt_pkg::CNT_W-1:0]  r_fill;

    logic [wrt_pkg::TICK_W-1:0] r_timeout;
    logic [wrt_pkg::RET_W-1:0]  r_limit;

    logic [wrt_pkg::TIME_W-1:0] r_now;
    logic [wrt_pkg::CNT_W-1:0]  r_idx;
    logic [wrt_pkg::CNT_W-1:0]  r_done_cnt;

    logic                       r_b_valid;
    logic [wrt_pkg::IDX_W-1:0]  r_b_idx;
    logic                       r_b_done;
    logic [wrt_pkg::SEQ_W-1:0]  r_b_seq;
    logic [wrt_pkg::TIME_W-1:0] r_b_sent;
    logic [wrt_pkg::RET_W-1:0]  r_b_retries;
    logic [wrt_pkg::PROD_W-1:0] r_b_prod;

    logic                       r_pend_valid;
    logic [wrt_pkg::KIND_W-1:0] r_pend_kind;
    logic [wrt_pkg::SEQ_W-1:0]  r_pend_seq;
    logic [wrt_pkg::RET_W-1:0]  r_pend_att;

    logic                       r_ev_valid;
    logic [wrt_pkg::KIND_W-1:0] r_ev_kind;
    logic [wrt_pkg::SEQ_W-1:0]  r_ev_seq;
    logic [wrt_pkg::RET_W-1:0]  r_ev_att;
    logic                       r_ev_last;

    logic                       n_ev_valid;
    logic [wrt_pkg::KIND_W-1:0] n_ev_kind;
    logic [wrt_pkg::SEQ_W-1:0]  n_ev_seq;
    logic [wrt_pkg::RET_W-1:0]  n_ev_att;
    logic                       n_ev_last;

    logic [wrt_pkg::IDX_W-1:0]  w_rd_idx;
    logic [wrt_pkg::IDX_W-1:0]  w_wr_idx;
    logic                       w_issue;
    logic [wrt_pkg::RET_W:0]    w_att_plus;
    logic [wrt_pkg::PROD_W-1:0] w_prod;
    logic [wrt_pkg::TIME_W:0]   w_deadline;
    logic                       w_expired;
    logic                       w_b_event;
    logic                       w_b_resend;
    logic [wrt_pkg::KIND_W-1:0] w_b_kind;
    logic [wrt_pkg::RET_W-1:0]  w_b_att;

    assign w_rd_idx   = r_idx[wrt_pkg::IDX_W-1:0];
    assign w_wr_idx   = r_fill[wrt_pkg::IDX_W-1:0];
    assign w_issue    = i_cmd.scan_step && (r_idx < r_fill);
    assign w_att_plus = {1'b0, r_retries[w_rd_idx]} + (wrt_pkg::RET_W + 1)'(1);
    assign w_prod     = wrt_pkg::PROD_W'(w_att_plus) * wrt_pkg::PROD_W'(r_timeout);
    assign w_deadline = {1'b0, r_b_sent} + (wrt_pkg::TIME_W + 1)'(r_b_prod);
    assign w_expired  = w_deadline < {1'b0, r_now};
    assign w_b_event  = r_b_valid && !r_b_done && w_expired;
    assign w_b_resend = r_b_retries < r_limit;
    assign w_b_kind   = w_b_resend ? wrt_pkg::EV_RESEND : wrt_pkg::EV_GIVEUP;
    assign w_b_att    = w_b_resend ? (r_b_retries + wrt_pkg::RET_W'(1)) : r_b_retries;

    assign o_stat.full     = (r_fill == wrt_pkg::CNT_W'(wrt_pkg::SLOTS));
    assign o_stat.scan_end = !(r_idx < r_fill) && !r_b_valid;
    assign o_stat.complete = (r_done_cnt == r_fill);
    assign o_stat.b_valid  = r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= wrt_pkg::TIMEOUT_RESET;
            r_limit   <= wrt_pkg::LIMIT_RESET;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                wrt_pkg::CFG_TIMEOUT: begin
                    r_timeout <= i_cfg_data;
                end
                wrt_pkg::CFG_RETRY_LIMIT: begin
                    r_limit <= i_cfg_data[wrt_pkg::RET_W-1:0];
                end
                default: begin
                    r_limit <= r_limit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send) begin
            r_seq[w_wr_idx]     <= i_seq_num;
            r_sent[w_wr_idx]    <= i_now_time;
            r_retries[w_wr_idx] <= '0;
        end else if (w_b_event && w_b_resend) begin
            r_retries[r_b_idx] <= w_b_att;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_fill <= '0;
        end else if (i_cmd.complete) begin
            r_done <= '0;
            r_fill <= '0;
        end else if (i_cmd.send) begin
            r_done[w_wr_idx] <= 1'b0;
            r_fill           <= r_fill + wrt_pkg::CNT_W'(1);
        end else if (i_cmd.ack) begin
            for (int k = 0; k < wrt_pkg::SLOTS; k++) begin
                if ((wrt_pkg::CNT_W'(k) < r_fill) && (r_seq[k] == i_seq_num)) begin
                    r_done[k] <= 1'b1;
                end
            end
        end else if (w_b_event && !w_b_resend) begin
            r_done[r_b_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_now      <= i_now_time;
            r_idx      <= '0;
            r_done_cnt <= '0;
        end else begin
            if (w_issue) begin
                r_idx <= r_idx + wrt_pkg::CNT_W'(1);
            end
            if (r_b_valid && r_b_done) begin
                r_done_cnt <= r_done_cnt + wrt_pkg::CNT_W'(1);
            end
        end
        if (w_issue) begin
            r_b_idx     <= w_rd_idx;
            r_b_done    <= r_done[w_rd_idx];
            r_b_seq     <= r_seq[w_rd_idx];
            r_b_sent    <= r_sent[w_rd_idx];
            r_b_retries <= r_retries[w_rd_idx];
            r_b_prod    <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.scan_init || i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end else if (w_b_event) begin
            r_pend_valid <= 1'b1;
        end
        if (w_b_event) begin
            r_pend_kind <= w_b_kind;
            r_pend_seq  <= r_b_seq;
            r_pend_att  <= w_b_att;
        end
    end

    always_comb begin
        n_ev_valid = 1'b0;
        n_ev_kind  = r_ev_kind;
        n_ev_seq   = r_ev_seq;
        n_ev_att   = r_ev_att;
        n_ev_last  = r_ev_last;
        if (i_cmd.overflow) begin
            n_ev_valid = 1'b1;
            n_ev_kind  = wrt_pkg::EV_OVERFLOW;
            n_ev_seq   = i_seq_num;
            n_ev_att   = '0;
            n_ev_last  = 1'b1;
        end else if (w_b_event && r_pend_valid) begin
            n_ev_valid = 1'b1;
            n_ev_kind  = r_pend_kind;
            n_ev_seq   = r_pend_seq;
            n_ev_att   = r_pend_att;
            n_ev_last  = 1'b0;
        end else if (i_cmd.flush && r_pend_valid) begin
            n_ev_valid = 1'b1;
            n_ev_kind  = r_pend_kind;
            n_ev_seq   = r_pend_seq;
            n_ev_att   = r_pend_att;
            n_ev_last  = !o_stat.complete;
        end else if (i_cmd.complete) begin
            n_ev_valid = 1'b1;
            n_ev_kind  = wrt_pkg::EV_COMPLETE;
            n_ev_seq   = '0;
            n_ev_att   = '0;
            n_ev_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else begin
            r_ev_valid <= n_ev_valid;
        end
        r_ev_kind <= n_ev_kind;
        r_ev_seq  <= n_ev_seq;
        r_ev_att  <= n_ev_att;
        r_ev_last <= n_ev_last;
    end

    assign o_event_valid = r_ev_valid;
    assign o_event_kind  = r_ev_kind;
    assign o_event_seq   = r_ev_seq;
    assign o_attempt_num = r_ev_att;
    assign o_last_event  = r_ev_last;

endmodule

// ===== sim/window_retransmit_tracker_tb.sv =====
module window_retransmit_tracker_tb;

    localparam logic [wrt_pkg::REQ_W-1:0] REQ_NONE = 2'd3;
    localparam int RANDOM_WORDS = 370;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [wrt_pkg::KIND_W-1:0] kind;
        logic [wrt_pkg::SEQ_W-1:0]  seq;
        logic [wrt_pkg::RET_W-1:0]  attempt;
        logic                       last;
    } t_ev_word;

    localparam t_ev_word NO_WORD = '0;

    typedef enum logic [1:0] {
        ROW_REQ,
        ROW_TYPED,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [wrt_pkg::REQ_W-1:0]   req;
        logic [wrt_pkg::SEQ_W-1:0]   seq;
        logic [wrt_pkg::TIME_W-1:0]  now;
        logic [wrt_pkg::CFG_W-1:0]   cfg_idx;
        logic [wrt_pkg::TICK_W-1:0]  cfg_val;
        int                          n_typed;
        t_ev_word                    typed;
    } t_stim_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_start;
    logic                         o_busy;
    logic [wrt_pkg::REQ_W-1:0]    i_req_type;
    logic [wrt_pkg::SEQ_W-1:0]    i_seq_num;
    logic [wrt_pkg::TIME_W-1:0]   i_now_time;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [wrt_pkg::CFG_W-1:0]    i_cfg_index;
    logic [wrt_pkg::TICK_W-1:0]   i_cfg_data;
    logic                         o_event_valid;
    logic [wrt_pkg::KIND_W-1:0]   o_event_kind;
    logic [wrt_pkg::SEQ_W-1:0]    o_event_seq;
    logic [wrt_pkg::RET_W-1:0]    o_attempt_num;
    logic                         o_last_event;

    logic [wrt_pkg::TICK_W-1:0]   m_timeout;
    logic [wrt_pkg::RET_W-1:0]    m_limit;
    logic [wrt_pkg::SEQ_W-1:0]    m_seq [wrt_pkg::SLOTS];
    logic [wrt_pkg::TIME_W-1:0]   m_time [wrt_pkg::SLOTS];
    logic [wrt_pkg::RET_W-1:0]    m_retries [wrt_pkg::SLOTS];
    logic                         m_done [wrt_pkg::SLOTS];
    int                           m_fill;

    t_ev_word            fresh_words [$];
    t_ev_word            due_events [$];
    bit                  word_taken;
    bit                  cfg_taken;
    bit                  typed_on;
    int                  typed_n;
    t_ev_word            typed_word;
    bit                  no_gaps;
    int                  n_items;
    int                  n_errors;
    int                  quiet_cycles;

    window_retransmit_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_req_type    (i_req_type),
        .i_seq_num     (i_seq_num),
        .i_now_time    (i_now_time),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_event_valid (o_event_valid),
        .o_event_kind  (o_event_kind),
        .o_event_seq   (o_event_seq),
        .o_attempt_num (o_attempt_num),
        .o_last_event  (o_last_event)
    );

    always #5 i_clk = ~i_clk;

    task automatic clear_window();
        for (int k = 0; k < wrt_pkg::SLOTS; k++) begin
            m_seq[k] = '0;
            m_time[k] = '0;
            m_retries[k] = '0;
            m_done[k] = 1'b0;
        end
        m_fill = 0;
    endtask

    task automatic track_request(input logic [wrt_pkg::REQ_W-1:0] req,
                                 input logic [wrt_pkg::SEQ_W-1:0] seq,
                                 input logic [wrt_pkg::TIME_W-1:0] now);
        int n_done;
        logic [63:0] due;
        t_ev_word w;
        fresh_words.delete();
        n_done = 0;
        case (req)
            wrt_pkg::REQ_SEND: begin
                if (m_fill < wrt_pkg::SLOTS) begin
                    m_seq[m_fill] = seq;
                    m_time[m_fill] = now;
                    m_retries[m_fill] = '0;
                    m_done[m_fill] = 1'b0;
                    m_fill++;
                end else begin
                    fresh_words.push_back('{wrt_pkg::EV_OVERFLOW, seq, 3'd0, 1'b0});
                end
            end
            wrt_pkg::REQ_ACK: begin
                for (int k = 0; k < m_fill; k++)
                    if (m_seq[k] == seq)
                        m_done[k] = 1'b1;
            end
            wrt_pkg::REQ_SCAN: begin
                for (int k = 0; k < m_fill; k++) begin
                    if (m_done[k]) begin
                        n_done++;
                    end else begin
                        due = 64'(m_time[k]) + (64'(m_retries[k]) + 64'd1) * 64'(m_timeout);
                        if (due < 64'(now)) begin
                            if (m_retries[k] < m_limit) begin
                                m_retries[k] = m_retries[k] + 3'd1;
                                fresh_words.push_back('{wrt_pkg::EV_RESEND, m_seq[k],
                                                        m_retries[k], 1'b0});
                            end else begin
                                m_done[k] = 1'b1;
                                fresh_words.push_back('{wrt_pkg::EV_GIVEUP, m_seq[k],
                                                        m_retries[k], 1'b0});
                            end
                        end
                    end
                end
                if (n_done == m_fill) begin
                    clear_window();
                    fresh_words.push_back('{wrt_pkg::EV_COMPLETE, 32'd0, 3'd0, 1'b0});
                end
            end
            default: ;
        endcase
        if (fresh_words.size() > 0) begin
            w = fresh_words.pop_back();
            w.last = 1'b1;
            fresh_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_ev_word want;
        word_taken = 1'b0;
        cfg_taken = 1'b0;
        if (i_rst_n) begin
            word_taken = i_start && !o_busy;
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (word_taken) begin
                track_request(i_req_type, i_seq_num, i_now_time);
                if (typed_on) begin
                    for (int k = 0; k < typed_n; k++)
                        due_events.push_back(typed_word);
                end else begin
                    foreach (fresh_words[k])
                        due_events.push_back(fresh_words[k]);
                end
            end
            if (cfg_taken) begin
                if (i_cfg_index == wrt_pkg::CFG_TIMEOUT)
                    m_timeout = i_cfg_data;
                else
                    m_limit = i_cfg_data[wrt_pkg::RET_W-1:0];
            end
            if (o_event_valid) begin
                if (due_events.size() == 0) begin
                    $error("unexpected result word: kind %0d seq %0h", o_event_kind, o_event_seq);
                    n_errors++;
                end else begin
                    want = due_events.pop_front();
                    if (o_event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, actual %0d", want.kind, o_event_kind);
                        n_errors++;
                    end
                    if (o_event_seq !== want.seq) begin
                        $error("event_seq: expected %0h, actual %0h", want.seq, o_event_seq);
                        n_errors++;
                    end
                    if (o_attempt_num !== want.attempt) begin
                        $error("attempt_num: expected %0d, actual %0d", want.attempt,
                               o_attempt_num);
                        n_errors++;
                    end
                    if (o_last_event !== want.last) begin
                        $error("last_event: expected %0d, actual %0d", want.last, o_last_event);
                        n_errors++;
                    end
                end
            end
            if (word_taken || cfg_taken || o_event_valid === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    always @(negedge i_clk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic issue(input logic [wrt_pkg::REQ_W-1:0] req,
                         input logic [wrt_pkg::SEQ_W-1:0] seq,
                         input logic [wrt_pkg::TIME_W-1:0] now);
        int gap;
        int r;
        i_start <= 1'b1;
        i_req_type <= req;
        i_seq_num <= seq;
        i_now_time <= now;
        do @(negedge i_clk); while (!word_taken);
        typed_on = 1'b0;
        if (req != REQ_NONE)
            n_items++;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [wrt_pkg::CFG_W-1:0] idx,
                             input logic [wrt_pkg::TICK_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // A scan that finds nothing due and leaves the window open gives no word, so wait out its walk as well.
    task automatic wait_idle();
        i_start <= 1'b0;
        while (due_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        t_stim_row plan [$];
        logic [wrt_pkg::TIME_W-1:0] t;
        logic [wrt_pkg::SEQ_W-1:0] pool [$];
        int n_send;
        int r;
        logic [wrt_pkg::SEQ_W-1:0] s;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_type = wrt_pkg::REQ_SEND;
        i_seq_num = '0;
        i_now_time = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = wrt_pkg::CFG_TIMEOUT;
        i_cfg_data = '0;
        m_timeout = wrt_pkg::TIMEOUT_RESET;
        m_limit = wrt_pkg::LIMIT_RESET;
        clear_window();
        typed_on = 1'b0;
        typed_n = 0;
        typed_word = NO_WORD;
        no_gaps = 1'b0;
        n_items = 0;
        n_errors = 0;
        quiet_cycles = 0;

        plan.push_back('{ROW_TYPED, wrt_pkg::REQ_SCAN, 32'h0, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 1,
                         '{wrt_pkg::EV_COMPLETE, 32'h0, 3'd0, 1'b1}});
        plan.push_back('{ROW_TYPED, REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_TYPED, wrt_pkg::REQ_ACK, 32'h0, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_TYPED, wrt_pkg::REQ_SEND, 32'hFFFF_FFFF, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_TYPED, wrt_pkg::REQ_SEND, 32'h0, 32'hFFFF_FFFF,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SEND, 32'h1234_5678, 32'd10,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        for (int k = 1; k <= 5; k++)
            plan.push_back('{ROW_REQ, wrt_pkg::REQ_SEND, 32'(k), 32'd10,
                             wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_TYPED, wrt_pkg::REQ_SEND, 32'hA5A5_A5A5, 32'd20,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 1,
                         '{wrt_pkg::EV_OVERFLOW, 32'hA5A5_A5A5, 3'd0, 1'b1}});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SCAN, 32'h0, 32'hFFFF_FFFF,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_TYPED, wrt_pkg::REQ_ACK, 32'd3, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SCAN, 32'h0, 32'hFFFF_FFFF,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_CFG, REQ_NONE, 32'h0, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'hFFFF, 0, NO_WORD});
        plan.push_back('{ROW_CFG, REQ_NONE, 32'h0, 32'h0,
                         wrt_pkg::CFG_RETRY_LIMIT, 16'hFFF8, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SCAN, 32'h0, 32'hFFFF_FFFF,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_ACK, 32'h0, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SCAN, 32'h0, 32'hFFFF_FFFF,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_CFG, REQ_NONE, 32'h0, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_CFG, REQ_NONE, 32'h0, 32'h0,
                         wrt_pkg::CFG_RETRY_LIMIT, 16'h7, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SEND, 32'd7, 32'd5,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SCAN, 32'h0, 32'd5,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SCAN, 32'h0, 32'd6,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_ACK, 32'd7, 32'h0,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});
        plan.push_back('{ROW_REQ, wrt_pkg::REQ_SCAN, 32'h0, 32'd6,
                         wrt_pkg::CFG_TIMEOUT, 16'h0, 0, NO_WORD});

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[i].cfg_idx, plan[i].cfg_val);
            end else begin
                typed_on = (plan[i].kind == ROW_TYPED);
                typed_n = plan[i].n_typed;
                typed_word = plan[i].typed;
                issue(plan[i].req, plan[i].seq, plan[i].now);
            end
        end

        // Each pass sends a random number of packets, scans the window with time moving on and some
        // acknowledgements and stray words mixed in, then closes it out.
        while (n_items < RANDOM_WORDS) begin
            wait_idle();
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    write_reg(wrt_pkg::CFG_TIMEOUT, 16'h0);
                else if (r < 30)
                    write_reg(wrt_pkg::CFG_TIMEOUT, 16'hFFFF);
                else
                    write_reg(wrt_pkg::CFG_TIMEOUT, 16'($urandom_range(1, 40)));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(wrt_pkg::CFG_RETRY_LIMIT, 16'($urandom));
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                t = 32'hFFFF_FFFF - 32'($urandom_range(0, 300000));
            else
                t = $urandom;
            pool.delete();
            n_send = $urandom_range(0, 10);
            for (int k = 0; k < n_send; k++) begin
                if (pool.size() > 0 && $urandom_range(0, 3) == 0)
                    s = pool[$urandom_range(0, pool.size() - 1)];
                else
                    s = $urandom;
                pool.push_back(s);
                issue(wrt_pkg::REQ_SEND, s, t);
                t = t + 32'($urandom_range(0, 3));
            end
            for (int k = 0; k < 30 && m_fill != 0; k++) begin
                r = $urandom_range(0, 99);
                if (r < 25 && pool.size() > 0)
                    issue(wrt_pkg::REQ_ACK, pool[$urandom_range(0, pool.size() - 1)], $urandom);
                else if (r < 32)
                    issue(wrt_pkg::REQ_W'($urandom_range(0, 3)), $urandom, $urandom);
                t = t + 32'($urandom_range(0, 2 * int'(m_timeout) + 2));
                issue(wrt_pkg::REQ_SCAN, $urandom, t);
            end
            for (int k = 0; k < m_fill; k++)
                if (!m_done[k])
                    issue(wrt_pkg::REQ_ACK, m_seq[k], $urandom);
            issue(wrt_pkg::REQ_SCAN, $urandom, t);
        end

        i_start <= 1'b0;
        while (due_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
